### rtl/stbq_pkg.sv
// Package: widths, register indexes, sequencer states and saturation helpers
`timescale 1ns / 1ps
`default_nettype none

package stbq_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 32;
    localparam int COEF_FRAC = 30;
    localparam int STATE_W   = 48;
    localparam int PROD_W    = COEF_W + SAMPLE_W;
    localparam int SUM_W     = STATE_W + 3;
    localparam int SHIFT_W   = SUM_W - COEF_FRAC;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_B0     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_B1     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_B2     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_A1     = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_A2     = CFG_IDX_W'(5);

    localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(64'sd1 <<< COEF_FRAC);
    localparam logic signed [SUM_W-1:0]  ROUND_HALF = SUM_W'(64'sd1 <<< (COEF_FRAC - 1));

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_B0,
        ST_SUM_Y,
        ST_SUM_B1,
        ST_SUM_A1,
        ST_SUM_B2,
        ST_SUM_A2,
        ST_OUT
    } seq_state_t;

    typedef enum logic [2:0] {
        COEF_SEL_B0,
        COEF_SEL_B1,
        COEF_SEL_B2,
        COEF_SEL_A1,
        COEF_SEL_A2
    } coef_sel_t;

    typedef enum logic [1:0] {
        ADD_D1,
        ADD_D2,
        ADD_ACC,
        ADD_ZERO
    } add_src_t;

    typedef struct packed {
        coef_sel_t coef_sel;
        logic      mul_use_y;
        add_src_t  add_src;
        logic      add_sub;
        logic      add_half;
        logic      load_y;
        logic      load_acc;
        logic      load_d1;
        logic      load_d2;
    } dp_ctrl_t;

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [SHIFT_W-1:0] v
    );
        logic [SHIFT_W-SAMPLE_W:0] top;
        logic signed [SAMPLE_W-1:0] r;
        top = v[SHIFT_W-1:SAMPLE_W-1];
        if ((&top) || !(|top))
            r = v[SAMPLE_W-1:0];
        else if (v[SHIFT_W-1])
            r = {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            r = {1'b0, {(SAMPLE_W-1){1'b1}}};
        return r;
    endfunction

    function automatic logic signed [STATE_W-1:0] sat_state(
        input logic signed [SUM_W-1:0] v
    );
        logic [SUM_W-STATE_W:0] top;
        logic signed [STATE_W-1:0] r;
        top = v[SUM_W-1:STATE_W-1];
        if ((&top) || !(|top))
            r = v[STATE_W-1:0];
        else if (v[SUM_W-1])
            r = {1'b1, {(STATE_W-1){1'b0}}};
        else
            r = {1'b0, {(STATE_W-1){1'b1}}};
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/stereo_biquad_highpass.sv
// Stereo biquad section, transposed direct form II, on one shared multiply-accumulate unit
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, left_in, right_in,    | in
//          | clear_history                             |
//  out     | out_valid, out_ready, left_out, right_out | out
//  cfg     | cfg_write_en, cfg_index, cfg_data         | in
//
// Filtering: each input is run through six multiply/add steps per channel on the
// single 32x16 multiplier and 51-bit adder; no new input is taken until both
// channels are done.
// Pass-through (filter disabled): input goes from idle straight to the output state.
// in_ready is high only while the sequencer is idle; the result register
// frees it once loaded, so a stalled output holds only the finished frame.
// Reset clears the delay state and loads the default coefficients.
`timescale 1ns / 1ps
`default_nettype none

module stereo_biquad_highpass (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [stbq_pkg::SAMPLE_W-1:0]  left_in,
    input  wire logic signed [stbq_pkg::SAMPLE_W-1:0]  right_in,
    input  wire logic                                  clear_history,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [stbq_pkg::SAMPLE_W-1:0]       left_out,
    output logic signed [stbq_pkg::SAMPLE_W-1:0]       right_out,
    input  wire logic                                  cfg_write_en,
    input  wire logic [stbq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [stbq_pkg::COEF_W-1:0]           cfg_data
);
    import stbq_pkg::*;

    seq_state_t state_reg, state_next;
    dp_ctrl_t   ctrl;

    logic                       enable_reg;
    logic signed [COEF_W-1:0]   b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic signed [STATE_W-1:0]  d1_reg [2];
    logic signed [STATE_W-1:0]  d2_reg [2];
    logic signed [SAMPLE_W-1:0] x_reg  [2];
    logic signed [SAMPLE_W-1:0] y_reg  [2];
    logic                       ch_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SUM_W-1:0]    acc_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] left_out_reg, right_out_reg;

    logic                       in_xfer;
    logic                       out_free;
    logic signed [COEF_W-1:0]   mul_a;
    logic signed [SAMPLE_W-1:0] mul_b;
    logic signed [PROD_W-1:0]   prod_full;
    logic signed [SUM_W-1:0]    opa;
    logic signed [SUM_W-1:0]    prod_ext;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SAMPLE_W-1:0] y_new;
    logic signed [STATE_W-1:0]  d_new;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        ctrl          = '0;
        ctrl.coef_sel = COEF_SEL_B0;
        ctrl.add_src  = ADD_ZERO;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = enable_reg ? ST_MUL_B0 : ST_OUT;
            end
            ST_MUL_B0:
            begin
                ctrl.coef_sel = COEF_SEL_B0;
                state_next    = ST_SUM_Y;
            end
            ST_SUM_Y:
            begin
                ctrl.add_src  = ADD_D1;
                ctrl.add_half = 1'b1;
                ctrl.load_y   = 1'b1;
                ctrl.coef_sel = COEF_SEL_B1;
                state_next    = ST_SUM_B1;
            end
            ST_SUM_B1:
            begin
                ctrl.add_src   = ADD_D2;
                ctrl.load_acc  = 1'b1;
                ctrl.coef_sel  = COEF_SEL_A1;
                ctrl.mul_use_y = 1'b1;
                state_next     = ST_SUM_A1;
            end
            ST_SUM_A1:
            begin
                ctrl.add_src  = ADD_ACC;
                ctrl.add_sub  = 1'b1;
                ctrl.load_d1  = 1'b1;
                ctrl.coef_sel = COEF_SEL_B2;
                state_next    = ST_SUM_B2;
            end
            ST_SUM_B2:
            begin
                ctrl.add_src   = ADD_ZERO;
                ctrl.load_acc  = 1'b1;
                ctrl.coef_sel  = COEF_SEL_A2;
                ctrl.mul_use_y = 1'b1;
                state_next     = ST_SUM_A2;
            end
            ST_SUM_A2:
            begin
                ctrl.add_src = ADD_ACC;
                ctrl.add_sub = 1'b1;
                ctrl.load_d2 = 1'b1;
                state_next   = ch_reg ? ST_OUT : ST_MUL_B0;
            end
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Shared multiplier and adder
    always_comb
    begin
        case (ctrl.coef_sel)
            COEF_SEL_B0: mul_a = b0_reg;
            COEF_SEL_B1: mul_a = b1_reg;
            COEF_SEL_B2: mul_a = b2_reg;
            COEF_SEL_A1: mul_a = a1_reg;
            COEF_SEL_A2: mul_a = a2_reg;
            default:     mul_a = b0_reg;
        endcase
    end

    assign mul_b     = ctrl.mul_use_y ? y_reg[ch_reg] : x_reg[ch_reg];
    assign prod_full = mul_a * mul_b;
    assign prod_ext  = SUM_W'(prod_reg);

    always_comb
    begin
        case (ctrl.add_src)
            ADD_D1:   opa = SUM_W'(d1_reg[ch_reg]);
            ADD_D2:   opa = SUM_W'(d2_reg[ch_reg]);
            ADD_ACC:  opa = acc_reg;
            ADD_ZERO: opa = '0;
            default:  opa = '0;
        endcase
    end

    assign sum   = opa + (ctrl.add_sub ? -prod_ext : prod_ext)
                 + (ctrl.add_half ? ROUND_HALF : SUM_W'(0));
    assign y_new = sat_sample(sum[SUM_W-1:COEF_FRAC]);
    assign d_new = sat_state(sum);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full;
        if (ctrl.load_acc)
            acc_reg <= sum;
        if (in_xfer)
        begin
            x_reg[0] <= left_in;
            x_reg[1] <= right_in;
            y_reg[0] <= left_in;
            y_reg[1] <= right_in;
        end
        else if (ctrl.load_y)
            y_reg[ch_reg] <= y_new;
        if ((state_reg == ST_OUT) && out_free)
        begin
            left_out_reg  <= y_reg[0];
            right_out_reg <= y_reg[1];
        end
    end

    // Delay state, channel pointer, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg[0]     <= '0;
            d1_reg[1]     <= '0;
            d2_reg[0]     <= '0;
            d2_reg[1]     <= '0;
            ch_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                ch_reg <= 1'b0;
                if (clear_history)
                begin
                    d1_reg[0] <= '0;
                    d1_reg[1] <= '0;
                    d2_reg[0] <= '0;
                    d2_reg[1] <= '0;
                end
            end
            if (ctrl.load_d1)
                d1_reg[ch_reg] <= d_new;
            if (ctrl.load_d2)
            begin
                d2_reg[ch_reg] <= d_new;
                ch_reg         <= 1'b1;
            end
            if ((state_reg == ST_OUT) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            b0_reg     <= COEF_ONE;
            b1_reg     <= '0;
            b2_reg     <= '0;
            a1_reg     <= '0;
            a2_reg     <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_ENABLE: enable_reg <= cfg_data[0];
                REG_B0:     b0_reg     <= cfg_data;
                REG_B1:     b1_reg     <= cfg_data;
                REG_B2:     b2_reg     <= cfg_data;
                REG_A1:     a1_reg     <= cfg_data;
                REG_A2:     a2_reg     <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Checks
    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && clear_history |=>
            d1_reg[0] == '0 && d1_reg[1] == '0 && d2_reg[0] == '0 && d2_reg[1] == '0)
        else $error("delay state not cleared");

    a_bypass_direct: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && !enable_reg |=> state_reg == ST_OUT)
        else $error("pass-through frame entered the filter sequence");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT && out_free |=> out_valid && in_ready)
        else $error("result not presented on completion");

    a_second_channel: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SUM_A2 && !ch_reg |=> state_reg == ST_MUL_B0 && ch_reg)
        else $error("right channel not sequenced after left");

endmodule

`default_nettype wire
